// ===== hdl/plist_pkg.sv =====
// plist_pkg: shared types and constants of the positional list engine
// operation and status codes, cell control word, sequencer states
// no dependencies
package plist_pkg;

  // default number of list slots
  localparam int unsigned PLIST_MAX_DEFAULT = 16;

  // fixed field widths
  localparam int unsigned PLIST_DATA_W = 32;
  localparam int unsigned PLIST_POS_W  = 5;
  localparam int unsigned PLIST_CNT_W  = 5;
  localparam int unsigned PLIST_CAP_W  = 5;
  localparam int unsigned PLIST_OP_W   = 3;
  localparam int unsigned PLIST_STAT_W = 2;

  // capacity after reset
  localparam int unsigned PLIST_CAP_RESET = 16;

  // operation codes, code seven is unused
  typedef enum logic [PLIST_OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_REVERSE = 3'd3,
    OP_SORT    = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_DUMP    = 3'd6
  } plist_op_e;

  // result status codes
  typedef enum logic [PLIST_STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } plist_status_e;

  // what every cell of the row does on a clock edge
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_ROTATE,
    CM_SORT
  } plist_cell_mode_e;

  typedef struct packed {
    plist_cell_mode_e mode;
    logic             phase;
  } plist_cell_ctrl_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_REV,
    S_SORT,
    S_DUMP
  } plist_state_e;

endpackage

// ===== hdl/plist_if.sv =====
// plist_if: valid/ready channels of the positional list engine
// input item, result item and capacity write channel
// depends on plist_pkg
interface plist_in_if import plist_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic        [PLIST_OP_W-1:0]   op;
  logic        [PLIST_POS_W-1:0]  position;
  logic signed [PLIST_DATA_W-1:0] value;

  modport source (output valid, op, position, value, input ready);
  modport sink (input valid, op, position, value, output ready);
endinterface

interface plist_out_if import plist_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic        [PLIST_STAT_W-1:0] status;
  logic signed [PLIST_DATA_W-1:0] data;
  logic        [PLIST_CNT_W-1:0]  entry_count;
  logic                           empty_flag;
  logic                           full_flag;
  logic                           last;

  modport source (output valid, status, data, entry_count, empty_flag, full_flag, last,
                  input ready);
  modport sink (input valid, status, data, entry_count, empty_flag, full_flag, last,
                output ready);
endinterface

interface plist_cfg_if import plist_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PLIST_CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface

// ===== hdl/plist_cell.sv =====
// plist_cell: one slot of the list, holds one entry
// talks to its two neighbors for shifts, rotations and compare-swap
// depends on plist_pkg
module plist_cell import plist_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = PLIST_MAX_DEFAULT,
  parameter int unsigned IDX         = 0
) (
  input  logic                                      clk_i,
  input  plist_cell_ctrl_t                          ctrl_i,
  input  logic        [$clog2(MAX_ENTRIES)-1:0]     pidx_i,
  input  logic        [$clog2(MAX_ENTRIES+1)-1:0]   cnt_i,
  input  logic signed [PLIST_DATA_W-1:0]            value_i,
  input  logic signed [PLIST_DATA_W-1:0]            left_i,
  input  logic signed [PLIST_DATA_W-1:0]            right_i,
  input  logic signed [PLIST_DATA_W-1:0]            head_i,
  input  logic                                      swap_left_i,
  output logic                                      swap_right_o,
  output logic signed [PLIST_DATA_W-1:0]            entry_o
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [IW-1:0] MY_IDX  = IW'(IDX);
  localparam logic [CW-1:0] NXT_IDX = CW'(IDX + 1);
  localparam logic          MY_PAR  = 1'(IDX % 2);

  logic signed [PLIST_DATA_W-1:0] entry_q, entry_d;

  // compare-swap with the right neighbor on this cell's sort phase
  assign swap_right_o = (ctrl_i.mode == CM_SORT) && (ctrl_i.phase == MY_PAR) &&
                        (NXT_IDX < cnt_i) && (entry_q > right_i);

  // next entry value
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.mode)
      CM_HOLD: entry_d = entry_q;
      CM_INSERT: begin
        if (MY_IDX == pidx_i) begin
          entry_d = value_i;
        end else if (MY_IDX > pidx_i) begin
          entry_d = left_i;
        end
      end
      CM_REMOVE: begin
        if (MY_IDX >= pidx_i) begin
          entry_d = right_i;
        end
      end
      CM_ROTATE: begin
        if (MY_IDX < pidx_i) begin
          entry_d = right_i;
        end else if (MY_IDX == pidx_i) begin
          entry_d = head_i;
        end
      end
      CM_SORT: begin
        if (swap_right_o) begin
          entry_d = right_i;
        end else if (swap_left_i) begin
          entry_d = left_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hdl/plist_chain.sv =====
// plist_chain: the row of list cells and their neighbor wiring
// slot zero is the head, broadcast back for rotations
// depends on plist_pkg and plist_cell
module plist_chain import plist_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = PLIST_MAX_DEFAULT
) (
  input  logic                                    clk_i,
  input  plist_cell_ctrl_t                        ctrl_i,
  input  logic        [$clog2(MAX_ENTRIES)-1:0]   pidx_i,
  input  logic        [$clog2(MAX_ENTRIES+1)-1:0] cnt_i,
  input  logic signed [PLIST_DATA_W-1:0]          value_i,
  output logic signed [PLIST_DATA_W-1:0]          entries_o [MAX_ENTRIES]
);

  logic swap_r [MAX_ENTRIES];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic signed [PLIST_DATA_W-1:0] left_w, right_w;
    logic                           swap_l_w;

    // left neighbor, the head cell sees itself
    if (g == 0) begin : g_head
      assign left_w   = entries_o[g];
      assign swap_l_w = 1'b0;
    end else begin : g_body
      assign left_w   = entries_o[g-1];
      assign swap_l_w = swap_r[g-1];
    end

    // right neighbor, the tail cell sees itself
    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign right_w = entries_o[g];
    end else begin : g_inner
      assign right_w = entries_o[g+1];
    end

    plist_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX         (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .pidx_i       (pidx_i),
      .cnt_i        (cnt_i),
      .value_i      (value_i),
      .left_i       (left_w),
      .right_i      (right_w),
      .head_i       (entries_o[0]),
      .swap_left_i  (swap_l_w),
      .swap_right_o (swap_r[g]),
      .entry_o      (entries_o[g])
    );
  end

endmodule

// ===== hdl/positional_list_engine_unit.sv =====
// positional_list_engine_unit: top level of the positional list engine
// sequencer, capacity register, result register and the cell row
// depends on plist_pkg, plist_if and plist_chain
//
// Usage:
//   cfg_ch writes the capacity register, always ready; write it only while idle.
//   in_ch takes one item (op, position, value) when valid and ready are high.
//   out_ch presents result items from a register; each item's final result has
//   last set. Only dump gives more than one result, one per live entry.
// Latency and throughput:
//   append, insert, delete, clear: any shift of the cell row happens in the same
//   edge that accepts the item, and the result is valid on the next cycle.
//   reverse: result on the next cycle, then busy rotating ever shorter prefixes.
//   sort: result on the next cycle, then busy with odd-even compare-swap rounds.
//   dump: count results, one per cycle while the receiver takes them; the
//   row rotates one slot per result and ends in its original order.
//   Rate is set by the single shared cell row: one item in flight at a time.
// Reset: count cleared, capacity set to 16; entries keep no reset value.
// Stall: while a result waits, a dump pauses and in_ch.ready stays low unless
//   the waiting result is taken in the same cycle; reverse and sort rounds run on.
module positional_list_engine_unit import plist_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = PLIST_MAX_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  plist_cfg_if.sink    cfg_ch,
  plist_in_if.sink     in_ch,
  plist_out_if.source  out_ch
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WW = (CW > PLIST_POS_W) ? CW : PLIST_POS_W;
  localparam int unsigned WX = WW + 1;

  plist_state_e                   state_q, state_d;
  logic        [CW-1:0]           cnt_q, cnt_d;
  logic        [CW-1:0]           step_q, step_d;
  logic        [CW-1:0]           cnt_last;
  logic        [PLIST_CAP_W-1:0]  cap_q;
  logic        [WW-1:0]           cap_w, eff_cap, cnt_w, pos_w, pos_m1;
  logic                           is_full, ins_bad, del_bad;
  logic signed [PLIST_DATA_W-1:0] entries [MAX_ENTRIES];
  logic signed [PLIST_DATA_W-1:0] del_data;
  plist_cell_ctrl_t               cell_ctrl;
  logic        [IW-1:0]           pidx;
  logic                           out_free, out_load, in_rdy;
  plist_status_e                  res_status;
  logic signed [PLIST_DATA_W-1:0] res_data;
  logic                           res_last;

  logic                           out_valid_q;
  plist_status_e                  out_status_q;
  logic signed [PLIST_DATA_W-1:0] out_data_q;
  logic        [PLIST_CNT_W-1:0]  out_cnt_q;
  logic                           out_empty_q, out_full_q, out_last_q;

  // capacity register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= PLIST_CAP_W'(PLIST_CAP_RESET);
    end else if (cfg_ch.valid) begin
      cap_q <= cfg_ch.capacity;
    end
  end

  // limits and position checks
  assign cap_w    = WW'(cap_q);
  assign eff_cap  = (cap_w > WW'(MAX_ENTRIES)) ? WW'(MAX_ENTRIES) : cap_w;
  assign cnt_w    = WW'(cnt_q);
  assign pos_w    = WW'(in_ch.position);
  assign pos_m1   = pos_w - WW'(1);
  assign is_full  = cnt_w >= eff_cap;
  assign ins_bad  = (pos_w == '0) || (WX'(pos_w) > (WX'(cnt_w) + WX'(1)));
  assign del_bad  = (pos_w == '0) || (pos_w > cnt_w);
  assign cnt_last = cnt_q - CW'(1);

  // value at the delete position
  always_comb begin
    del_data = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (WW'(i) == pos_m1) begin
        del_data = entries[i];
      end
    end
  end

  assign out_free = !out_valid_q || out_ch.ready;

  // sequencer: next state, cell control and result
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    cell_ctrl  = '{mode: CM_HOLD, phase: 1'b0};
    pidx       = '0;
    out_load   = 1'b0;
    in_rdy     = 1'b0;
    res_status = STAT_OK;
    res_data   = '0;
    res_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_rdy = out_free;
        if (in_ch.valid && out_free) begin
          out_load = 1'b1;
          case (in_ch.op)
            OP_APPEND: begin
              if (is_full) begin
                res_status = STAT_FULL;
              end else begin
                cell_ctrl.mode = CM_INSERT;
                pidx           = IW'(cnt_q);
                cnt_d          = cnt_q + CW'(1);
              end
            end
            OP_INSERT: begin
              if (is_full) begin
                res_status = STAT_FULL;
              end else if (ins_bad) begin
                res_status = STAT_BADPOS;
              end else begin
                cell_ctrl.mode = CM_INSERT;
                pidx           = IW'(pos_m1);
                cnt_d          = cnt_q + CW'(1);
              end
            end
            OP_DELETE: begin
              if (cnt_q == '0) begin
                res_status = STAT_EMPTY;
              end else if (del_bad) begin
                res_status = STAT_BADPOS;
              end else begin
                cell_ctrl.mode = CM_REMOVE;
                pidx           = IW'(pos_m1);
                res_data       = del_data;
                cnt_d          = cnt_last;
              end
            end
            OP_REVERSE: begin
              if (cnt_q > CW'(1)) begin
                state_d = S_REV;
                step_d  = cnt_last;
              end
            end
            OP_SORT: begin
              if (cnt_q > CW'(1)) begin
                state_d = S_SORT;
                step_d  = '0;
              end
            end
            OP_CLEAR: cnt_d = '0;
            OP_DUMP: begin
              if (cnt_q == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                out_load = 1'b0;
                state_d  = S_DUMP;
                step_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      // rotate prefix [0..step] left, moving the head to slot step
      S_REV: begin
        cell_ctrl.mode = CM_ROTATE;
        pidx           = IW'(step_q);
        if (step_q == CW'(1)) begin
          state_d = S_IDLE;
        end else begin
          step_d = step_q - CW'(1);
        end
      end
      // one odd-even transposition round per cycle
      S_SORT: begin
        cell_ctrl.mode  = CM_SORT;
        cell_ctrl.phase = step_q[0];
        if (step_q == cnt_last) begin
          state_d = S_IDLE;
        end else begin
          step_d = step_q + CW'(1);
        end
      end
      // emit the head and rotate the whole list by one, when the result register is free
      S_DUMP: begin
        if (out_free) begin
          out_load       = 1'b1;
          res_data       = entries[0];
          res_last       = (step_q == cnt_last);
          cell_ctrl.mode = CM_ROTATE;
          pidx           = IW'(cnt_last);
          if (step_q == cnt_last) begin
            state_d = S_IDLE;
          end else begin
            step_d = step_q + CW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ch.ready = in_rdy;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status;
      out_data_q   <= res_data;
      out_cnt_q    <= PLIST_CNT_W'(cnt_d);
      out_empty_q  <= (cnt_d == '0);
      out_full_q   <= (WW'(cnt_d) >= eff_cap);
      out_last_q   <= res_last;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.status      = out_status_q;
  assign out_ch.data        = out_data_q;
  assign out_ch.entry_count = out_cnt_q;
  assign out_ch.empty_flag  = out_empty_q;
  assign out_ch.full_flag   = out_full_q;
  assign out_ch.last        = out_last_q;

  // cell row
  plist_chain #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (cell_ctrl),
    .pidx_i    (pidx),
    .cnt_i     (cnt_q),
    .value_i   (in_ch.value),
    .entries_o (entries)
  );

endmodule

// ===== hdl/plist_checker.sv =====
// plist_checker: port-level checks of the positional list engine
// bound to positional_list_engine_unit at the end of this file
// depends on plist_pkg
module plist_checker import plist_pkg::*; (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic        [PLIST_OP_W-1:0]   in_op,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic        [PLIST_STAT_W-1:0] out_status,
  input logic signed [PLIST_DATA_W-1:0] out_data,
  input logic        [PLIST_CNT_W-1:0]  out_entry_count,
  input logic                           out_empty_flag,
  input logic                           out_full_flag
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_status))
    else $error("result changed while stalled");

  // any item other than dump shows its result on the next cycle
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_op != OP_DUMP) |=> out_valid)
    else $error("single result not presented");

  // a full report comes with the full flag and no data
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status == STAT_FULL) |-> out_full_flag && (out_data == '0))
    else $error("full status inconsistent");

  // an empty report comes with a zero count
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status == STAT_EMPTY) |->
      out_empty_flag && (out_entry_count == '0) && (out_data == '0))
    else $error("empty status inconsistent");

endmodule

bind positional_list_engine_unit plist_checker u_plist_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_op           (in_ch.op),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_data        (out_ch.data),
  .out_entry_count (out_ch.entry_count),
  .out_empty_flag  (out_ch.empty_flag),
  .out_full_flag   (out_ch.full_flag)
);
